### hw/rtl/ptree_pkg.sv
// shared types and constants for the palindromic tree append block
// no dependencies
`timescale 1ns / 1ps

package ptree_pkg;

  localparam int unsigned RES_W = 13;
  localparam int unsigned LTR_W = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NODE_RD,
    ST_NODE_CHK,
    ST_LTR_CHK,
    ST_CHILD_RD,
    ST_CHILD_CHK,
    ST_CHILD_VAL,
    ST_WRITE
  } state_e;

endpackage

### hw/rtl/palindromic_tree_append_top.sv
// palindromic tree (eertree) append unit: letter, node and child memories
// depends on ptree_pkg
`timescale 1ns / 1ps
// a dropped or out-of-range letter is answered straight from idle; otherwise the main walk
// follows suffix links (node read, length check, letter check) and ends on the child lookup
// when the child exists, or a new node walks the link chain as well before it is written
// one item at a time; the next letter can be accepted while the result is strobed
// results are strobed for one cycle; the receiver cannot stall
// reset: async active low; clears control, tree is empty, no memory sweep

module palindromic_tree_append_top
  import ptree_pkg::*;
#(
  parameter int unsigned MAX_LEN  = 4096,
  parameter int unsigned ALPHABET = 26
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [LTR_W-1:0] letter_i,
  output logic             result_valid_o,
  output logic [RES_W-1:0] suffix_palindromes_o,
  output logic [RES_W-1:0] longest_suffix_len_o,
  output logic             full_res_o
);

  localparam int unsigned PW = $clog2(MAX_LEN + 1);
  localparam int unsigned NW = $clog2(MAX_LEN + 2);
  localparam int unsigned LW = NW + 1;
  localparam int unsigned IW = LW + 1;
  localparam int unsigned CDEPTH = (MAX_LEN + 2) * ALPHABET;
  localparam int unsigned CW = $clog2(CDEPTH);
  localparam int unsigned RW = LW + 3 * NW + LTR_W;

  // node record: length, link, depth, parent, edge letter
  logic [RW-1:0]    node_mem  [MAX_LEN+2];
  logic [NW-1:0]    child_mem [CDEPTH];
  logic [LTR_W-1:0] ltr_mem   [MAX_LEN+1];

  logic [RW-1:0]    node_rdata_q;
  logic [NW-1:0]    child_rdata_q;
  logic [LTR_W-1:0] ltr_rdata_q;

  logic             node_we, child_we, ltr_we;
  logic [NW-1:0]    node_addr;
  logic [RW-1:0]    node_wdata;
  logic [CW-1:0]    child_addr;
  logic [PW-1:0]    ltr_addr;
  logic [NW-1:0]    child_base;

  state_e state_q, state_d;
  logic [PW-1:0]        pos_q, pos_d;
  logic [NW-1:0]        last_q, last_d;
  logic [NW-1:0]        top_q, top_d;
  logic [LTR_W-1:0]     c_q, c_d;
  logic [NW-1:0]        v_q, v_d;
  logic                 phase_q, phase_d;
  logic [NW-1:0]        cur_q, cur_d;
  logic signed [LW-1:0] cur_len_q, cur_len_d;
  logic [NW-1:0]        cur_link_q, cur_link_d;
  logic signed [LW-1:0] vlen_q, vlen_d;
  logic [NW-1:0]        lnk_q, lnk_d;
  logic [NW-1:0]        dep_q, dep_d;
  logic                 valid_q, valid_d;
  logic [RES_W-1:0]     sp_q, sp_d, ln_q, ln_d;
  logic                 full_q, full_d;

  logic signed [LW-1:0] nd_len;
  logic [NW-1:0]        nd_link, nd_depth, nd_parent;
  logic [LTR_W-1:0]     nd_edge;
  logic signed [IW-1:0] idx;
  logic                 ltr_bad;
  logic                 child_ok;
  logic                 walk_hit;
  logic signed [LW-1:0] new_len;

  assign busy = (state_q != ST_IDLE);
  assign ltr_bad = (32'(letter_i) >= ALPHABET);
  assign new_len = cur_len_q + LW'(2);

  // root lengths and links are constants, everything else comes from the node memory
  always_comb begin
    if (v_q == NW'(0)) begin
      nd_len = '0;
      nd_link = NW'(1);
    end else if (v_q == NW'(1)) begin
      nd_len = '1;
      nd_link = '0;
    end else begin
      nd_len  = node_rdata_q[RW-1 -: LW];
      nd_link = node_rdata_q[RW-LW-1 -: NW];
    end
    nd_depth  = node_rdata_q[RW-LW-NW-1 -: NW];
    nd_parent = node_rdata_q[LTR_W +: NW];
    nd_edge   = node_rdata_q[LTR_W-1:0];
    idx = IW'($signed({1'b0, pos_q})) - IW'(nd_len) - IW'(1);
    walk_hit = (nd_len < 0);
    // the node being created has no record yet
    child_ok = (child_rdata_q >= NW'(2)) && (child_rdata_q <= top_q)
               && !(phase_q && (child_rdata_q == top_q));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start && !ltr_bad && (32'(pos_q) < MAX_LEN)) state_d = ST_NODE_RD;
      end
      ST_NODE_RD: state_d = ST_NODE_CHK;
      ST_NODE_CHK: begin
        if (walk_hit) state_d = ST_CHILD_RD;
        else if (idx < 1) state_d = ST_NODE_RD;
        else state_d = ST_LTR_CHK;
      end
      ST_LTR_CHK: begin
        if (ltr_rdata_q == c_q) state_d = ST_CHILD_RD;
        else state_d = ST_NODE_RD;
      end
      ST_CHILD_RD: state_d = ST_CHILD_CHK;
      ST_CHILD_CHK: begin
        if (child_ok) state_d = ST_CHILD_VAL;
        else if (phase_q) state_d = ST_WRITE;
        else state_d = ST_NODE_RD;
      end
      ST_CHILD_VAL: begin
        if ((nd_parent == v_q) && (nd_edge == c_q)) begin
          state_d = phase_q ? ST_WRITE : ST_IDLE;
        end else begin
          state_d = phase_q ? ST_WRITE : ST_NODE_RD;
        end
      end
      ST_WRITE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    pos_d = pos_q;       last_d = last_q;   top_d = top_q;
    c_d = c_q;           v_d = v_q;         phase_d = phase_q;
    cur_d = cur_q;       cur_len_d = cur_len_q;  cur_link_d = cur_link_q;
    vlen_d = vlen_q;     lnk_d = lnk_q;     dep_d = dep_q;
    valid_d = 1'b0;      sp_d = sp_q;       ln_d = ln_q;   full_d = full_q;
    node_we = 1'b0;      child_we = 1'b0;   ltr_we = 1'b0;
    node_addr = v_q;
    node_wdata = {new_len, lnk_q, dep_q, cur_q, c_q};
    ltr_addr = PW'(pos_q + PW'(1));
    child_base = v_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          c_d = letter_i;
          if (ltr_bad) begin
            valid_d = 1'b1; sp_d = '0; ln_d = '0; full_d = 1'b0;
          end else if (32'(pos_q) >= MAX_LEN) begin
            valid_d = 1'b1; sp_d = '0; ln_d = '0; full_d = 1'b1;
          end else begin
            pos_d = PW'(pos_q + PW'(1));
            ltr_we = 1'b1;
            v_d = last_q;
            phase_d = 1'b0;
          end
        end
      end
      ST_NODE_RD: ;
      ST_NODE_CHK: begin
        vlen_d = nd_len;
        lnk_d = nd_link;
        ltr_addr = PW'(idx);
        if (walk_hit) begin
          if (!phase_q) begin
            cur_d = v_q; cur_len_d = nd_len; cur_link_d = nd_link;
          end
        end else if (idx < 1) begin
          v_d = nd_link;
        end
      end
      ST_LTR_CHK: begin
        if (ltr_rdata_q == c_q) begin
          if (!phase_q) begin
            cur_d = v_q; cur_len_d = vlen_q; cur_link_d = lnk_q;
          end
        end else begin
          v_d = lnk_q;
        end
      end
      ST_CHILD_RD: ;
      ST_CHILD_CHK: begin
        node_addr = child_rdata_q;
        if (!child_ok) begin
          if (phase_q) begin
            lnk_d = '0; dep_d = NW'(1);
          end else begin
            top_d = top_q + NW'(1); v_d = cur_link_q; phase_d = 1'b1;
          end
        end
      end
      ST_CHILD_VAL: begin
        if ((nd_parent == v_q) && (nd_edge == c_q)) begin
          if (phase_q) begin
            lnk_d = child_rdata_q; dep_d = nd_depth + NW'(1);
          end else begin
            last_d = child_rdata_q;
            valid_d = 1'b1; full_d = 1'b0;
            sp_d = RES_W'(nd_depth);
            ln_d = RES_W'($unsigned(node_rdata_q[RW-1 -: LW]));
          end
        end else if (phase_q) begin
          lnk_d = '0; dep_d = NW'(1);
        end else begin
          top_d = top_q + NW'(1); v_d = cur_link_q; phase_d = 1'b1;
        end
      end
      ST_WRITE: begin
        node_we = 1'b1;
        node_addr = top_q;
        child_we = 1'b1;
        child_base = cur_q;
        last_d = top_q;
        valid_d = 1'b1; full_d = 1'b0;
        sp_d = RES_W'(dep_q);
        ln_d = RES_W'($unsigned(new_len));
      end
      default: ;
    endcase
    child_addr = CW'(child_base * ALPHABET + c_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q <= '0;
      last_q <= '0;
      top_q <= NW'(1);
      phase_q <= 1'b0;
      valid_q <= 1'b0;
      sp_q <= '0;
      ln_q <= '0;
      full_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q <= pos_d;
      last_q <= last_d;
      top_q <= top_d;
      phase_q <= phase_d;
      valid_q <= valid_d;
      sp_q <= sp_d;
      ln_q <= ln_d;
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
    v_q <= v_d;
    cur_q <= cur_d;
    cur_len_q <= cur_len_d;
    cur_link_q <= cur_link_d;
    vlen_q <= vlen_d;
    lnk_q <= lnk_d;
    dep_q <= dep_d;
  end

  always_ff @(posedge clk_i) begin
    if (node_we) node_mem[node_addr] <= node_wdata;
    node_rdata_q <= node_mem[node_addr];
  end

  always_ff @(posedge clk_i) begin
    if (child_we) child_mem[child_addr] <= top_q;
    child_rdata_q <= child_mem[child_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ltr_we) ltr_mem[ltr_addr] <= letter_i;
    ltr_rdata_q <= ltr_mem[ltr_addr];
  end

  assign result_valid_o = valid_q;
  assign suffix_palindromes_o = sp_q;
  assign longest_suffix_len_o = ln_q;
  assign full_res_o = full_q;

endmodule

### hw/rtl/ptree_chk.sv
// port checker for the palindromic tree append unit, bound to the top level
// depends on ptree_pkg
`timescale 1ns / 1ps

module ptree_chk
  import ptree_pkg::*;
#(
  parameter int unsigned ALPHABET = 26
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic [LTR_W-1:0] letter_i,
  input logic             result_valid_o,
  input logic [RES_W-1:0] suffix_palindromes_o,
  input logic [RES_W-1:0] longest_suffix_len_o,
  input logic             full_res_o
);

  // a full flag never comes with counts
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_res_o |-> (suffix_palindromes_o == '0) && (longest_suffix_len_o == '0))
    else $error("full result with nonzero counts");

  // out-of-range letter gives an immediate all-zero item
  a_bad_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (32'(letter_i) >= ALPHABET)) |=>
      (result_valid_o && !full_res_o && (suffix_palindromes_o == '0)
       && (longest_suffix_len_o == '0)))
    else $error("out-of-range letter not answered with zeros");

  // an item only shows up after an accept or while working
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(start) || $past(busy)))
    else $error("result without an item in flight");

  // idle block stays idle without start
  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !start) |=> !busy)
    else $error("busy raised without start");

endmodule

bind palindromic_tree_append_top ptree_chk #(.ALPHABET(ALPHABET)) u_ptree_chk (.*);
